@@ rtl/oll_pkg.sv @@
// ----------------------------------------------------------------------------
// oll_pkg
// Shared constants and types of the ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package oll_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int OCC_W    = $clog2(CAPACITY + 1);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // Cell operation codes.
  localparam int CELL_OP_W = 3;
  localparam logic [CELL_OP_W-1:0] CELL_HOLD    = 3'd0;
  localparam logic [CELL_OP_W-1:0] CELL_SHIFT_R = 3'd1;
  localparam logic [CELL_OP_W-1:0] CELL_LOAD    = 3'd2;
  localparam logic [CELL_OP_W-1:0] CELL_REMOVE  = 3'd3;
  localparam logic [CELL_OP_W-1:0] CELL_ROTATE  = 3'd4;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic [CELL_OP_W-1:0]     op;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] head;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/oll_cell.sv @@
// ----------------------------------------------------------------------------
// oll_cell
// One list slot: holds an entry, compares it and hands it to a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module oll_cell (
  input  wire                                 clk,
  input  wire oll_pkg::cell_ctrl_t            ctrl,
  input  wire                                 at_occ,
  input  wire                                 at_tail,
  input  wire                                 below,
  input  wire logic signed [oll_pkg::DATA_W-1:0] left_data,
  input  wire logic signed [oll_pkg::DATA_W-1:0] right_data,
  input  wire                                 found_in,
  output logic signed [oll_pkg::DATA_W-1:0]   data,
  output logic                                found_out
);

  logic signed [oll_pkg::DATA_W-1:0] data_next;

  // The search carry: set from the first live cell that matches onward.
  assign found_out = found_in | (below & (data == ctrl.value));

  always_comb begin
    data_next = data;
    case (ctrl.op)
      oll_pkg::CELL_SHIFT_R: data_next = left_data;
      oll_pkg::CELL_LOAD: begin
        if (at_occ) data_next = ctrl.value;
      end
      oll_pkg::CELL_REMOVE: begin
        if (found_out) data_next = right_data;
      end
      oll_pkg::CELL_ROTATE: begin
        data_next = at_tail ? ctrl.head : right_data;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

@@ rtl/ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed 32-bit values held in a chain of compare/shift cells.
// ----------------------------------------------------------------------------
// The engine keeps up to CAPACITY entries in a row of cells, front of the list
// in cell 0. Insert front, insert back, remove and clear each complete at once:
// every cell compares and shifts in parallel, and a new command is taken in
// the next cycle as long as the result register is free or being drained.
// Each of these commands returns one status transfer with last set. During a
// dump of n entries the chain rotates one place per cycle while the result
// register is free, the head cell feeds the result register and wraps to
// the tail, so after n steps the list is back in its original order. No
// command is taken while a dump streams. A dump of an empty list returns one
// status transfer. Entries beyond the current count are never read, so the
// cells carry no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     cmd_valid,
  output logic                                    cmd_ready,
  input  wire logic [oll_pkg::CMD_W-1:0]          cmd,
  input  wire logic signed [oll_pkg::DATA_W-1:0]  value,
  output logic                                    res_valid,
  input  wire                                     res_ready,
  output logic [oll_pkg::STATUS_W-1:0]            status,
  output logic [oll_pkg::COUNT_W-1:0]             count,
  output logic signed [oll_pkg::DATA_W-1:0]       element,
  output logic                                    last
);

  localparam int N = oll_pkg::CAPACITY;
  localparam int W = oll_pkg::OCC_W;

  // Control state.
  logic [W-1:0] occ, occ_next;
  logic         dumping, dumping_next;
  logic [W-1:0] remaining, remaining_next;
  logic         res_valid_next;

  // Result register payload.
  logic [oll_pkg::STATUS_W-1:0]      status_next;
  logic [oll_pkg::COUNT_W-1:0]       count_next;
  logic signed [oll_pkg::DATA_W-1:0] element_next;
  logic                              last_next;
  logic                              load_res;

  oll_pkg::cell_ctrl_t ctrl;
  logic [oll_pkg::CELL_OP_W-1:0] cell_op;

  logic signed [oll_pkg::DATA_W-1:0] cell_data [N];
  logic [N:0]                        found_chain;
  logic                              found;

  logic res_free;
  logic accept;

  assign res_free  = !res_valid || res_ready;
  assign cmd_ready = !dumping && res_free;
  assign accept    = cmd_valid && cmd_ready;

  assign found_chain[0] = 1'b0;
  assign found          = found_chain[N];

  assign ctrl.op    = cell_op;
  assign ctrl.value = value;
  assign ctrl.head  = cell_data[0];

  // The row of cells. Cell 0 takes the input value on a front insert, and the
  // last cell sees itself as its right neighbor.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [oll_pkg::DATA_W-1:0] left_d;
    logic signed [oll_pkg::DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = value;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == N - 1) begin : g_end
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    oll_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .at_occ     (occ == W'(i)),
      .at_tail    (occ == W'(i + 1)),
      .below      (W'(i) < occ),
      .left_data  (left_d),
      .right_data (right_d),
      .found_in   (found_chain[i]),
      .data       (cell_data[i]),
      .found_out  (found_chain[i+1])
    );
  end

  // Command sequencing.
  always_comb begin
    cell_op        = oll_pkg::CELL_HOLD;
    occ_next       = occ;
    dumping_next   = dumping;
    remaining_next = remaining;
    load_res       = 1'b0;
    status_next    = oll_pkg::ST_OK;
    element_next   = '0;
    last_next      = 1'b1;

    if (accept) begin
      load_res = 1'b1;
      case (cmd)
        oll_pkg::CMD_INS_FRONT: begin
          if (occ >= W'(N)) begin
            status_next = oll_pkg::ST_FULL;
          end else begin
            cell_op  = oll_pkg::CELL_SHIFT_R;
            occ_next = occ + W'(1);
          end
        end
        oll_pkg::CMD_INS_BACK: begin
          if (occ >= W'(N)) begin
            status_next = oll_pkg::ST_FULL;
          end else begin
            cell_op  = oll_pkg::CELL_LOAD;
            occ_next = occ + W'(1);
          end
        end
        oll_pkg::CMD_REMOVE: begin
          if (occ == '0) begin
            status_next = oll_pkg::ST_EMPTY;
          end else if (!found) begin
            status_next = oll_pkg::ST_NOTFOUND;
          end else begin
            cell_op  = oll_pkg::CELL_REMOVE;
            occ_next = occ - W'(1);
          end
        end
        oll_pkg::CMD_CLEAR: begin
          if (occ == '0) begin
            status_next = oll_pkg::ST_EMPTY;
          end else begin
            occ_next = '0;
          end
        end
        oll_pkg::CMD_DUMP: begin
          if (occ == '0) begin
            status_next = oll_pkg::ST_EMPTY;
          end else begin
            // Entries go out in the following cycles.
            load_res       = 1'b0;
            dumping_next   = 1'b1;
            remaining_next = occ;
          end
        end
        default: status_next = oll_pkg::ST_OK;
      endcase
    end else if (dumping && res_free) begin
      // Send the head entry and rotate it round to the tail.
      load_res       = 1'b1;
      cell_op        = oll_pkg::CELL_ROTATE;
      element_next   = cell_data[0];
      last_next      = (remaining == W'(1));
      remaining_next = remaining - W'(1);
      if (remaining == W'(1)) dumping_next = 1'b0;
    end

    count_next = oll_pkg::COUNT_W'(occ_next);

    if (load_res) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      dumping   <= 1'b0;
      remaining <= '0;
      res_valid <= 1'b0;
    end else begin
      occ       <= occ_next;
      dumping   <= dumping_next;
      remaining <= remaining_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      status  <= status_next;
      count   <= count_next;
      element <= element_next;
      last    <= last_next;
    end
  end

endmodule

`default_nettype wire
